[sv/rvp_pkg.sv]
package rvp_pkg;

  localparam int LIM_W = 11;
  localparam int IDX_W = 4;

  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [7:0] VP8_START_DESC   = 8'h10;
  localparam logic [7:0] VP8_CONT_DESC    = 8'h00;

  // byte positions inside a packet opening
  localparam logic [IDX_W-1:0] POS_DESC = 4'd12;
  localparam logic [IDX_W-1:0] POS_DATA = 4'd13;
  localparam int               OPEN_BYTES = 13;

  // configuration register indexes
  localparam logic [1:0] REG_SOURCE_ID     = 2'd0;
  localparam logic [1:0] REG_PAYLOAD_TYPE  = 2'd1;
  localparam logic [1:0] REG_TIME_STEP     = 2'd2;
  localparam logic [1:0] REG_PAYLOAD_LIMIT = 2'd3;

  localparam logic [31:0]      RST_SOURCE_ID     = 32'd0;
  localparam logic [6:0]       RST_PAYLOAD_TYPE  = 7'd96;
  localparam logic [15:0]      RST_TIME_STEP     = 16'd1500;
  localparam logic [LIM_W-1:0] RST_PAYLOAD_LIMIT = 11'd1187;

  // one accepted frame byte with everything its packet opening needs
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        need_hdr;
    logic        marker;
    logic        first_pkt;
    logic        packet_end;
    logic [15:0] seq;
    logic [31:0] ts;
  } pkt_item_t;

endpackage

[sv/rtp_vp8_packetizer.sv]
// flow: an accepted byte enters the hold register, then the output register once that
//   is free; a byte opening a packet first sends 12 rtp header bytes and the vp8 descriptor
// throughput: one output and, inside a packet, one input byte per cycle unless out_tready
//   stalls; an opening byte holds input while the single output byte lane sends its header
// reset: synchronous active-low rst_n clears sequence, timestamp, frame offset, packet fill
//   and all valid flags, and loads the register reset values
module rtp_vp8_packetizer
  import rvp_pkg::*;
#(
  parameter int MTU_BYTES   = 1200,
  parameter int LENGTH_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input requests, tdata padded to whole bytes
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [((8 + LENGTH_BITS + 7) / 8) * 8 - 1:0] in_tdata,
                                              // [7:0] data_byte, then frame_length, zero pad
  // output requests
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [7:0]              out_tdata,  // [7:0] out_byte
  output logic                    out_tlast,  // packet_end
  output logic                    out_tuser,  // [0] run_end
  // configuration writes
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data
);

  localparam int CMP_W = (LENGTH_BITS > LIM_W) ? LENGTH_BITS : LIM_W;
  // most frame bytes that fit after the header and descriptor
  localparam logic [LIM_W-1:0] LIMIT_CAP = LIM_W'(MTU_BYTES - OPEN_BYTES);

  // configuration registers
  logic [31:0]      source_id_r;
  logic [6:0]       payload_type_r;
  logic [15:0]      time_step_r;
  logic [LIM_W-1:0] payload_limit_r;

  // packetizer state
  logic [15:0]            seq_r;
  logic [31:0]            ts_r;
  logic [LENGTH_BITS-1:0] offset_r;
  logic [LIM_W-1:0]       fill_r;

  logic                   accept;
  logic [7:0]             in_byte;
  logic [LENGTH_BITS-1:0] flen_raw;
  logic [LENGTH_BITS-1:0] flen;
  logic [LIM_W-1:0]       limit;
  logic [LENGTH_BITS-1:0] remaining;
  logic [LENGTH_BITS:0]   next_off;
  logic [LIM_W-1:0]       fill_nxt;
  logic                   frame_done;
  logic                   packet_done;
  logic                   marker;
  pkt_item_t              item;

  assign in_byte  = in_tdata[7:0];
  assign flen_raw = in_tdata[8 +: LENGTH_BITS];
  // a zero length counts as a one-byte frame
  assign flen     = (flen_raw == '0) ? LENGTH_BITS'(1) : flen_raw;

  // limit clamped to 1..cap
  always_comb begin
    limit = payload_limit_r;
    if (limit == '0) begin
      limit = LIM_W'(1);
    end
    if (limit > LIMIT_CAP) begin
      limit = LIMIT_CAP;
    end
  end

  // marker when the rest of the frame fits into this packet
  assign remaining = (offset_r < flen) ? (flen - offset_r) : LENGTH_BITS'(1);
  assign marker    = CMP_W'(remaining) <= CMP_W'(limit);

  assign next_off    = {1'b0, offset_r} + 1'b1;
  assign frame_done  = next_off >= {1'b0, flen};
  assign fill_nxt    = fill_r + 1'b1;
  assign packet_done = frame_done || (fill_nxt >= limit);

  assign accept = in_tvalid && in_tready;

  always_comb begin
    item.data_byte  = in_byte;
    item.need_hdr   = (fill_r == '0);
    item.marker     = marker;
    item.first_pkt  = (offset_r == '0);
    item.packet_end = packet_done;
    item.seq        = seq_r;
    item.ts         = ts_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_id_r     <= RST_SOURCE_ID;
      payload_type_r  <= RST_PAYLOAD_TYPE;
      time_step_r     <= RST_TIME_STEP;
      payload_limit_r <= RST_PAYLOAD_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_ID:     source_id_r     <= cfg_data;
        REG_PAYLOAD_TYPE:  payload_type_r  <= cfg_data[6:0];
        REG_TIME_STEP:     time_step_r     <= cfg_data[15:0];
        REG_PAYLOAD_LIMIT: payload_limit_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // state advances when the byte is accepted; the item carries the old values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r    <= '0;
      ts_r     <= '0;
      offset_r <= '0;
      fill_r   <= '0;
    end else if (accept) begin
      if (packet_done) begin
        seq_r  <= seq_r + 1'b1;
        fill_r <= '0;
      end else begin
        fill_r <= fill_nxt;
      end
      if (frame_done) begin
        ts_r     <= ts_r + {16'd0, time_step_r};
        offset_r <= '0;
      end else begin
        offset_r <= next_off[LENGTH_BITS-1:0];
      end
    end
  end

  // holds one item, walks its opening bytes and feeds the output register
  rvp_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (in_tvalid),
    .item         (item),
    .item_ready   (in_tready),
    .source_id    (source_id_r),
    .payload_type (payload_type_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser)
  );

endmodule

[sv/rvp_emit.sv]
module rvp_emit
  import rvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  pkt_item_t   item,
  output logic        item_ready,
  input  logic [31:0] source_id,
  input  logic [6:0]  payload_type,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tlast,   // packet_end
  output logic        out_tuser    // [0] run_end
);

  logic             hold_v_r;
  pkt_item_t        hold_r;
  logic [IDX_W-1:0] idx_r;
  logic             out_v_r;
  logic [7:0]       out_byte_r;
  logic             out_pend_r;
  logic             out_run_r;

  logic       out_free;
  logic       emit;
  logic       is_last;
  logic       take;
  logic [7:0] cur_byte;

  assign out_free   = !out_v_r || out_tready;
  assign emit       = hold_v_r && out_free;
  assign is_last    = !hold_r.need_hdr || (idx_r == POS_DATA);
  assign take       = !hold_v_r || (emit && is_last);
  assign item_ready = take;

  always_comb begin
    cur_byte = hold_r.data_byte;
    if (hold_r.need_hdr) begin
      case (idx_r)
        4'd0:     cur_byte = RTP_VERSION_BYTE;
        4'd1:     cur_byte = {hold_r.marker, payload_type};
        4'd2:     cur_byte = hold_r.seq[15:8];
        4'd3:     cur_byte = hold_r.seq[7:0];
        4'd4:     cur_byte = hold_r.ts[31:24];
        4'd5:     cur_byte = hold_r.ts[23:16];
        4'd6:     cur_byte = hold_r.ts[15:8];
        4'd7:     cur_byte = hold_r.ts[7:0];
        4'd8:     cur_byte = source_id[31:24];
        4'd9:     cur_byte = source_id[23:16];
        4'd10:    cur_byte = source_id[15:8];
        4'd11:    cur_byte = source_id[7:0];
        POS_DESC: cur_byte = hold_r.first_pkt ? VP8_START_DESC : VP8_CONT_DESC;
        default:  cur_byte = hold_r.data_byte;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      idx_r    <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (take) begin
        hold_v_r <= item_valid;
        idx_r    <= '0;
      end else if (emit) begin
        idx_r <= idx_r + 1'b1;
      end
      if (out_free) begin
        out_v_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && item_valid) begin
      hold_r <= item;
    end
    if (emit) begin
      out_byte_r <= cur_byte;
      out_pend_r <= is_last && hold_r.packet_end;
      out_run_r  <= is_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_pend_r;
  assign out_tuser  = out_run_r;

endmodule
